// ===== rtl/core/ltrd_pkg.sv =====
// Shared types, codes and sizes for the LZ77 token run decoder.
package ltrd_pkg;

   // Default sizes. The history size must be a power of two.
   localparam int HISTORY_SIZE_DEFAULT = 4096;
   localparam int MAX_RUN_DEFAULT      = 64;

   localparam int DATA_W     = 8;
   localparam int COUNT_W    = 32;
   localparam int TOKEN_W    = 32;
   localparam int MAXDIST_W  = 12;
   localparam int MINLEN_W   = 4;
   localparam int DIVISOR_W  = MAXDIST_W + 1;
   localparam int RUN_LEN_W  = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Command codes.
   localparam logic [1:0] OP_LITERAL = 2'd0;
   localparam logic [1:0] OP_RUN     = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_BYTE     = 2'd0;
   localparam logic [1:0] STAT_END      = 2'd1;
   localparam logic [1:0] STAT_TOO_LONG = 2'd2;
   localparam logic [1:0] STAT_RESTART  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_BYTES  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_DIV,
      ST_RUN
   } ltrd_state_type;

   typedef enum logic [2:0] {
      DV_IDLE,
      DV_MUL,
      DV_CHECK,
      DV_ITER,
      DV_DONE
   } ltrd_div_state_type;

   typedef struct packed {
      logic                 done;
      logic                 too_long;
      logic [RUN_LEN_W-1:0] length;
      logic [MAXDIST_W-1:0] distance;
   } ltrd_div_result_type;

endpackage

// ===== rtl/core/lz77_token_run_decoder_unit.sv =====
// LZ77 token run decoder: command sequencing, history copy and result register.
//
// Commands arrive on the req_ channel (req_op, req_literal, req_token) and
// are taken one at a time; req_stall is low only while no command is in work.
// Results leave on the rsp_ channel through a single output register, so a
// new command is taken while the previous result still waits to be read.
// A literal, a restart or a command at the end of the stream passes through
// ST_SINGLE, which loads its one result into the output register once that is
// free and returns to ST_IDLE for the next command. A run token first passes
// the divider that splits it into length and distance: a step to form the
// length bound, a compare, a restoring division of clog2(MAX_RUN + 1) quotient
// bits (one quotient bit a cycle) and a hand-over step. The copy then reads
// the history memory and gives one byte a cycle while the output is free.
// An overlong run is caught at the compare, skips the division and gives its
// status through ST_SINGLE.
// While a result waits under rsp_stall the copy pauses and the pending byte is re-read.
// Reset clears the byte count, the configuration registers to their defaults
// and the output valid flag; the history memory needs no clearing pass.
// HISTORY_SIZE must be a power of two. Registers must be written through csr_
// only while no transaction is in work; the block itself does not enforce it.
module lz77_token_run_decoder_unit
   import ltrd_pkg::*;
#(
   parameter int HISTORY_SIZE = HISTORY_SIZE_DEFAULT,
   parameter int MAX_RUN      = MAX_RUN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic [DATA_W-1:0]     req_literal,
   input  logic [TOKEN_W-1:0]    req_token,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_W-1:0]     rsp_data_byte,
   output logic                  rsp_last,
   output logic [1:0]            rsp_status,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int ADDR_W = $clog2(HISTORY_SIZE);
   localparam int BACK_W = (ADDR_W > DIVISOR_W) ? ADDR_W : DIVISOR_W;

   ltrd_state_type       state_ff, state_in;
   logic [COUNT_W-1:0]   bytes_out_ff, bytes_out_in;
   logic [MAXDIST_W-1:0] max_distance_ff, max_distance_in;
   logic [MINLEN_W-1:0]  min_length_ff, min_length_in;
   logic [COUNT_W-1:0]   total_bytes_ff, total_bytes_in;
   logic [DATA_W-1:0]    single_byte_ff, single_byte_in;
   logic [1:0]           single_status_ff, single_status_in;
   logic [ADDR_W-1:0]    src_ff, src_in;
   logic [RUN_LEN_W-1:0] run_cnt_ff, run_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_data_byte_ff, rsp_data_byte_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic                 rsp_free;
   logic                 at_end;
   logic                 div_start;
   ltrd_div_result_type  div_res;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [DATA_W-1:0]    wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [DATA_W-1:0]    rd_data;
   logic [DIVISOR_W-1:0] back;
   logic [BACK_W-1:0]    src_diff;
   logic [ADDR_W-1:0]    src_first;

   ltrd_token_div #(
      .MAX_RUN (MAX_RUN)
   ) u_token_div (
      .clock        (clock),
      .reset        (reset),
      .start        (div_start),
      .token        (req_token),
      .max_distance (max_distance_ff),
      .min_length   (min_length_ff),
      .result       (div_res)
   );

   ltrd_history_ram #(
      .HISTORY_SIZE (HISTORY_SIZE)
   ) u_history_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         bytes_out_ff    <= '0;
         max_distance_ff <= MAXDIST_W'(4095);
         min_length_ff   <= MINLEN_W'(2);
         total_bytes_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         bytes_out_ff    <= bytes_out_in;
         max_distance_ff <= max_distance_in;
         min_length_ff   <= min_length_in;
         total_bytes_ff  <= total_bytes_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      single_byte_ff   <= single_byte_in;
      single_status_ff <= single_status_in;
      src_ff           <= src_in;
      run_cnt_ff       <= run_cnt_in;
      rsp_data_byte_ff <= rsp_data_byte_in;
      rsp_last_ff      <= rsp_last_in;
      rsp_status_ff    <= rsp_status_in;
   end

   always_comb begin
      max_distance_in = max_distance_ff;
      min_length_in   = min_length_ff;
      total_bytes_in  = total_bytes_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_DISTANCE: max_distance_in = csr_write_data[MAXDIST_W-1:0];
            CSR_MIN_LENGTH:   min_length_in   = csr_write_data[MINLEN_W-1:0];
            CSR_TOTAL_BYTES:  total_bytes_in  = csr_write_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The copy source sits distance + 1 bytes behind the write position.
   assign back      = DIVISOR_W'(div_res.distance) + DIVISOR_W'(1);
   assign src_diff  = BACK_W'(bytes_out_ff[ADDR_W-1:0]) - BACK_W'(back);
   assign src_first = src_diff[ADDR_W-1:0];

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign at_end   = bytes_out_ff >= total_bytes_ff;

   always_comb begin
      state_in         = state_ff;
      bytes_out_in     = bytes_out_ff;
      single_byte_in   = single_byte_ff;
      single_status_in = single_status_ff;
      src_in           = src_ff;
      run_cnt_in       = run_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_data_byte_in = rsp_data_byte_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_status_in    = rsp_status_ff;
      req_stall        = state_ff != ST_IDLE;
      div_start        = 1'b0;
      wr_en            = 1'b0;
      wr_addr          = bytes_out_ff[ADDR_W-1:0];
      wr_data          = rd_data;
      rd_en            = 1'b0;
      rd_addr          = src_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_RESTART: begin
                     bytes_out_in     = '0;
                     single_byte_in   = '0;
                     single_status_in = STAT_RESTART;
                     state_in         = ST_SINGLE;
                  end
                  OP_LITERAL, OP_RUN: begin
                     if (at_end) begin
                        single_byte_in   = '0;
                        single_status_in = STAT_END;
                        state_in         = ST_SINGLE;
                     end else if (req_op == OP_LITERAL) begin
                        wr_en            = 1'b1;
                        wr_data          = req_literal;
                        bytes_out_in     = bytes_out_ff + COUNT_W'(1);
                        single_byte_in   = req_literal;
                        single_status_in = STAT_BYTE;
                        state_in         = ST_SINGLE;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SINGLE: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_byte_in = single_byte_ff;
               rsp_last_in      = 1'b1;
               rsp_status_in    = single_status_ff;
               state_in         = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               if (div_res.too_long) begin
                  single_byte_in   = '0;
                  single_status_in = STAT_TOO_LONG;
                  state_in         = ST_SINGLE;
               end else if (div_res.length == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en      = 1'b1;
                  rd_addr    = src_first;
                  src_in     = src_first;
                  run_cnt_in = div_res.length;
                  state_in   = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // Without a free output slot the current source byte is read again.
            rd_en = 1'b1;
            if (rsp_free) begin
               wr_en            = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_data_byte_in = rd_data;
               rsp_last_in      = run_cnt_ff == RUN_LEN_W'(1);
               rsp_status_in    = STAT_BYTE;
               bytes_out_in     = bytes_out_ff + COUNT_W'(1);
               src_in           = src_ff + ADDR_W'(1);
               rd_addr          = src_ff + ADDR_W'(1);
               run_cnt_in       = run_cnt_ff - RUN_LEN_W'(1);
               if (run_cnt_ff == RUN_LEN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_byte_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== rtl/core/ltrd_history_ram.sv =====
// Circular history memory with a registered read port and write-to-read forwarding.
module ltrd_history_ram
   import ltrd_pkg::*;
#(
   parameter int HISTORY_SIZE = HISTORY_SIZE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [$clog2(HISTORY_SIZE)-1:0] wr_addr,
   input  logic [DATA_W-1:0]               wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(HISTORY_SIZE)-1:0] rd_addr,
   output logic [DATA_W-1:0]               rd_data
);

   logic [DATA_W-1:0] mem [HISTORY_SIZE];
   logic [DATA_W-1:0] mem_q_ff;
   logic [DATA_W-1:0] fwd_data_ff;
   logic              fwd_ff;
   logic              fwd_in;

   assign fwd_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff    <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // A read of the entry written in the same cycle returns the new byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : mem_q_ff;

endmodule

// ===== rtl/core/ltrd_token_div.sv =====
// Splits a run token into length and distance with a bit-serial restoring divider.
module ltrd_token_div
   import ltrd_pkg::*;
#(
   parameter int MAX_RUN = MAX_RUN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TOKEN_W-1:0]   token,
   input  logic [MAXDIST_W-1:0] max_distance,
   input  logic [MINLEN_W-1:0]  min_length,
   output ltrd_div_result_type  result
);

   localparam int LEN_W = $clog2(MAX_RUN + 1);
   localparam int REM_W = LEN_W + DIVISOR_W;
   localparam int LIM_W = LEN_W + 1 + DIVISOR_W;
   localparam int IDX_W = $clog2(LEN_W);
   localparam int SUM_W = LEN_W + MINLEN_W;
   localparam logic [LEN_W:0] RUN_P1 = (LEN_W+1)'(MAX_RUN + 1);

   ltrd_div_state_type   state_ff, state_in;
   logic [TOKEN_W-1:0]   token_ff, token_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [MINLEN_W-1:0]  min_length_ff, min_length_in;
   logic [LIM_W-1:0]     limit_ff, limit_in;
   logic                 over_ff, over_in;
   logic                 too_long_ff, too_long_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]     quot_ff, quot_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [LEN_W:0]       quot_limit;
   logic [REM_W-1:0]     trial;
   logic [SUM_W-1:0]     len_sum;
   logic                 div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      token_ff      <= token_in;
      divisor_ff    <= divisor_in;
      min_length_ff <= min_length_in;
      limit_ff      <= limit_in;
      over_ff       <= over_in;
      too_long_ff   <= too_long_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      idx_ff        <= idx_in;
   end

   // The quotient may be at most MAX_RUN - min_length, so the token must stay
   // below (MAX_RUN + 1 - min_length) times the divisor.
   assign quot_limit = RUN_P1 - (LEN_W+1)'(min_length_ff);
   assign trial      = REM_W'(divisor_ff) << idx_ff;
   assign len_sum    = SUM_W'(quot_ff) + SUM_W'(min_length_ff);

   always_comb begin
      state_in      = state_ff;
      token_in      = token_ff;
      divisor_in    = divisor_ff;
      min_length_in = min_length_ff;
      limit_in      = limit_ff;
      over_in       = over_ff;
      too_long_in   = too_long_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      idx_in        = idx_ff;
      div_done      = 1'b0;

      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               token_in      = token;
               divisor_in    = DIVISOR_W'(max_distance) + DIVISOR_W'(1);
               min_length_in = min_length;
               state_in      = DV_MUL;
            end
         end
         DV_MUL: begin
            limit_in = LIM_W'(quot_limit) * LIM_W'(divisor_ff);
            over_in  = 32'(min_length_ff) > MAX_RUN;
            state_in = DV_CHECK;
         end
         DV_CHECK: begin
            if (over_ff || (token_ff >= TOKEN_W'(limit_ff))) begin
               too_long_in = 1'b1;
               state_in    = DV_DONE;
            end else begin
               too_long_in = 1'b0;
               rem_in      = token_ff[REM_W-1:0];
               quot_in     = '0;
               idx_in      = IDX_W'(LEN_W - 1);
               state_in    = DV_ITER;
            end
         end
         DV_ITER: begin
            if (rem_ff >= trial) begin
               rem_in          = rem_ff - trial;
               quot_in[idx_ff] = 1'b1;
            end
            if (idx_ff == '0) begin
               state_in = DV_DONE;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         DV_DONE: begin
            div_done = 1'b1;
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   assign result.done     = div_done;
   assign result.too_long = too_long_ff;
   assign result.length   = RUN_LEN_W'(len_sum);
   assign result.distance = rem_ff[MAXDIST_W-1:0];

endmodule

// ===== rtl/core/ltrd_checker.sv =====
// Port-level assertions for the LZ77 token run decoder, bound to the top level.
module ltrd_checker
   import ltrd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [DATA_W-1:0] rsp_data_byte,
   input logic              rsp_last,
   input logic [1:0]        rsp_status
);

   // A stalled result transaction keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_last) && $stable(rsp_status))
      else $error("stalled result changed");

   // Only a copied or literal byte may carry data or be followed by more results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_BYTE) |-> rsp_last && (rsp_data_byte == '0))
      else $error("status result carries data or is not last");

   // A run streams one byte a cycle while each byte is taken with rsp_stall low.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside a run");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind lz77_token_run_decoder_unit ltrd_checker u_ltrd_checker (.*);
